### hdl/y2r_pkg.sv
// Shared types, constants and helpers for the YUV 4:2:0 to RGB converter.
`timescale 1ns / 1ps
package y2r_pkg;

  // Frame store
  localparam int STORE_BYTES = 131072;
  localparam int MEM_AW      = $clog2(STORE_BYTES);

  // Field widths
  localparam int DIM_W      = 9;
  localparam int COORD_W    = 8;
  localparam int PIX_W      = 8;
  localparam int LAYOUT_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Address arithmetic: w*h plus both chroma planes stays below 2^20
  localparam int CALC_W = 20;
  localparam int AMUL_A_W = DIM_W + 1;
  localparam int AMUL_P_W = AMUL_A_W + DIM_W;

  // Input word layout, lowest bit first
  localparam int IN_ADDR_LSB  = 0;
  localparam int IN_VALUE_LSB = IN_ADDR_LSB + MEM_AW;
  localparam int IN_COL_LSB   = IN_VALUE_LSB + PIX_W;
  localparam int IN_ROW_LSB   = IN_COL_LSB + COORD_W;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 3 * PIX_W;

  // Color math in Q16
  localparam int K_W   = 18;
  localparam int DIF_W = PIX_W + 1;
  localparam int ACC_W = K_W + DIF_W;
  localparam logic signed [K_W-1:0] K_RV = 18'sd91881;
  localparam logic signed [K_W-1:0] K_GU = 18'sd22554;
  localparam logic signed [K_W-1:0] K_GV = 18'sd46802;
  localparam logic signed [K_W-1:0] K_BU = 18'sd116130;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [LAYOUT_W-1:0] LAYOUT_NV21 = 3'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_NV12 = 3'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_YU12 = 3'd2;
  localparam logic [LAYOUT_W-1:0] LAYOUT_YV12 = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_LAYOUT = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YADDR,
    ST_YRD,
    ST_CMUL,
    ST_HMUL,
    ST_C0RD,
    ST_C1RD,
    ST_CLAT,
    ST_MB,
    ST_MR,
    ST_MGU,
    ST_MGV,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    AMUL_NONE,
    AMUL_Y_ROW,
    AMUL_BASE,
    AMUL_CHROMA_ROW,
    AMUL_HALF_PLANE
  } amul_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_Y,
    RD_C0,
    RD_C1
  } rd_e;

  typedef enum logic [2:0] {
    COL_NONE,
    COL_B,
    COL_R,
    COL_GU,
    COL_GV
  } col_e;

  typedef struct packed {
    logic  take_pixel;
    logic  mem_we;
    rd_e   rd;
    amul_e amul;
    logic  lat_y;
    logic  lat_c0;
    logic  lat_c1;
    col_e  col;
    logic  out_load;
  } cmd_t;

  // Truncate a Q16 sum toward zero and clamp to 0..255
  function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-18:0] hi;
    hi = v[ACC_W-2:16];
    if (v[ACC_W-1]) begin
      return '0;
    end else if (hi > (ACC_W-17)'(255)) begin
      return '1;
    end else begin
      return hi[PIX_W-1:0];
    end
  endfunction

endpackage

### hdl/yuv420_frame_to_rgb_converter_unit.sv
// Top level of the YUV 4:2:0 frame store and BT.601 full-range pixel converter.
`timescale 1ns / 1ps
// A load word (tuser 0) writes one byte into the 128 KiB frame store in the
// cycle it is accepted and gives no result. A pixel word (tuser 1) fetches
// Y, U and V through the single-port frame store and returns one BGR word;
// the block stays busy from acceptance until it is ready again, its schedule
// set by the one-read-per-cycle store port (three reads), the shared
// address multiplier (four products) and the shared color multiplier (four
// products). A finished result waits in an output register, so a following
// load or pixel word is accepted while it waits. Addresses past the store
// read as zero; an unknown chroma layout gives U = V = 0. Write width,
// height and layout only while the block is idle.
module yuv420_frame_to_rgb_converter_unit
  import y2r_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // byte_address[16:0], byte_value[24:17], pixel_column[32:25], pixel_row[40:33]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // kind[0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // blue[7:0], green[15:8], red[23:16]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  y2r_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  y2r_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### hdl/y2r_ctrl.sv
// Sequencer for frame loads and per-pixel fetch and color conversion.
`timescale 1ns / 1ps
module y2r_ctrl
  import y2r_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_kind_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == KIND_PIXEL) begin
            cmd_o.take_pixel = 1'b1;
            state_d          = ST_YADDR;
          end else begin
            cmd_o.mem_we = 1'b1;
          end
        end
      end
      ST_YADDR: begin
        cmd_o.amul = AMUL_Y_ROW;
        state_d    = ST_YRD;
      end
      ST_YRD: begin
        cmd_o.rd   = RD_Y;
        cmd_o.amul = AMUL_BASE;
        state_d    = ST_CMUL;
      end
      ST_CMUL: begin
        cmd_o.lat_y = 1'b1;
        cmd_o.amul  = AMUL_CHROMA_ROW;
        state_d     = ST_HMUL;
      end
      ST_HMUL: begin
        cmd_o.amul = AMUL_HALF_PLANE;
        state_d    = ST_C0RD;
      end
      ST_C0RD: begin
        cmd_o.rd = RD_C0;
        state_d  = ST_C1RD;
      end
      ST_C1RD: begin
        cmd_o.rd     = RD_C1;
        cmd_o.lat_c0 = 1'b1;
        state_d      = ST_CLAT;
      end
      ST_CLAT: begin
        cmd_o.lat_c1 = 1'b1;
        state_d      = ST_MB;
      end
      ST_MB: begin
        cmd_o.col = COL_B;
        state_d   = ST_MR;
      end
      ST_MR: begin
        cmd_o.col = COL_R;
        state_d   = ST_MGU;
      end
      ST_MGU: begin
        cmd_o.col = COL_GU;
        state_d   = ST_MGV;
      end
      ST_MGV: begin
        cmd_o.col = COL_GV;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/y2r_datapath.sv
// Frame store, configuration registers, address and color arithmetic.
`timescale 1ns / 1ps
module y2r_datapath
  import y2r_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  cmd_t                   cmd_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  logic [DIM_W-1:0]    width_q, height_q;
  logic [LAYOUT_W-1:0] layout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      layout_q <= LAYOUT_NV12;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_LAYOUT: layout_q <= cfg_data_i[LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input word fields
  logic [MEM_AW-1:0]  ld_addr;
  logic [PIX_W-1:0]   ld_value;
  logic [COORD_W-1:0] col_in, row_in;

  assign ld_addr  = in_data_i[IN_ADDR_LSB +: MEM_AW];
  assign ld_value = in_data_i[IN_VALUE_LSB +: PIX_W];
  assign col_in   = in_data_i[IN_COL_LSB +: COORD_W];
  assign row_in   = in_data_i[IN_ROW_LSB +: COORD_W];

  logic [COORD_W-1:0] x_q, y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pixel) begin
      x_q <= col_in;
      y_q <= row_in;
    end
  end

  // Derived geometry
  logic                semi;
  logic                odd_w;
  logic [COORD_W-2:0]  crow;
  logic [DIM_W-2:0]    half_w, half_h;
  logic [AMUL_A_W-1:0] stride;

  assign semi   = (layout_q == LAYOUT_NV21) || (layout_q == LAYOUT_NV12);
  assign odd_w  = width_q[0];
  assign crow   = y_q[COORD_W-1:1];
  assign half_w = width_q[DIM_W-1:1];
  assign half_h = height_q[DIM_W-1:1];
  assign stride = {1'b0, width_q} + {{(AMUL_A_W-1){1'b0}}, odd_w};

  // Shared address multiplier
  logic [AMUL_A_W-1:0] ma;
  logic [DIM_W-1:0]    mb;
  logic [AMUL_P_W-1:0] mprod;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.amul)
      AMUL_Y_ROW: begin
        ma = AMUL_A_W'(y_q);
        mb = width_q;
      end
      AMUL_BASE: begin
        ma = AMUL_A_W'(width_q);
        mb = height_q;
      end
      AMUL_CHROMA_ROW: begin
        ma = semi ? stride : AMUL_A_W'(half_w);
        mb = DIM_W'(crow);
      end
      AMUL_HALF_PLANE: begin
        ma = AMUL_A_W'(half_w);
        mb = DIM_W'(half_h);
      end
      default: ;
    endcase
  end

  assign mprod = ma * mb;

  logic [AMUL_P_W-1:0] yrow_q, base_q, crow_q, hplane_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.amul)
      AMUL_Y_ROW:      yrow_q   <= mprod;
      AMUL_BASE:       base_q   <= mprod;
      AMUL_CHROMA_ROW: crow_q   <= mprod;
      AMUL_HALF_PLANE: hplane_q <= mprod;
      default: ;
    endcase
  end

  // Read addresses
  logic [CALC_W-1:0] y_addr, addr0, addr1, inc1, rd_addr;
  logic [COORD_W:0]  off0;
  logic [CALC_W-1:0] addr0_q;

  always_comb begin
    if (semi) begin
      off0 = {1'b0, x_q[COORD_W-1:1], 1'b0};
      inc1 = CALC_W'(1);
    end else begin
      off0 = (COORD_W+1)'(x_q[COORD_W-1:1]) + (odd_w ? (COORD_W+1)'(crow) : '0);
      inc1 = CALC_W'(hplane_q) + (odd_w ? CALC_W'(half_h) : '0);
    end
  end

  assign y_addr = CALC_W'(yrow_q) + CALC_W'(x_q);
  assign addr0  = CALC_W'(base_q) + CALC_W'(crow_q) + CALC_W'(off0);
  assign addr1  = addr0_q + inc1;

  always_comb begin
    case (cmd_i.rd)
      RD_Y:    rd_addr = y_addr;
      RD_C0:   rd_addr = addr0;
      RD_C1:   rd_addr = addr1;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd == RD_C0) begin
      addr0_q <= addr0;
    end
  end

  // Single-port frame store
  logic [PIX_W-1:0]  mem [STORE_BYTES];
  logic [PIX_W-1:0]  mem_q;
  logic [MEM_AW-1:0] mem_addr;
  logic              mem_re;
  logic              oob_q;
  logic [PIX_W-1:0]  rd_byte;

  assign mem_re   = (cmd_i.rd != RD_NONE);
  assign mem_addr = cmd_i.mem_we ? ld_addr : rd_addr[MEM_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[mem_addr] <= ld_value;
    end
    if (mem_re) begin
      mem_q <= mem[mem_addr];
      oob_q <= (rd_addr >= CALC_W'(STORE_BYTES));
    end
  end

  // reads past the store give zero
  assign rd_byte = oob_q ? '0 : mem_q;

  logic [PIX_W-1:0] luma_q, ch0_q, ch1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_y)  luma_q <= rd_byte;
    if (cmd_i.lat_c0) ch0_q  <= rd_byte;
    if (cmd_i.lat_c1) ch1_q  <= rd_byte;
  end

  // Chroma selection per layout
  logic [PIX_W-1:0] u_val, v_val;

  always_comb begin
    case (layout_q)
      LAYOUT_NV21, LAYOUT_YV12: begin
        u_val = ch1_q;
        v_val = ch0_q;
      end
      LAYOUT_NV12, LAYOUT_YU12: begin
        u_val = ch0_q;
        v_val = ch1_q;
      end
      default: begin
        u_val = '0;
        v_val = '0;
      end
    endcase
  end

  logic signed [DIF_W-1:0] du, dv;

  assign du = $signed({1'b0, u_val}) - $signed(DIF_W'(128));
  assign dv = $signed({1'b0, v_val}) - $signed(DIF_W'(128));

  // Shared color multiplier
  logic signed [K_W-1:0]   kc;
  logic signed [DIF_W-1:0] dc;
  logic signed [ACC_W-1:0] cprod, ybase;
  logic signed [ACC_W-1:0] b_q, r_q, g_q;

  always_comb begin
    case (cmd_i.col)
      COL_B: begin
        kc = K_BU;
        dc = du;
      end
      COL_R: begin
        kc = K_RV;
        dc = dv;
      end
      COL_GU: begin
        kc = K_GU;
        dc = du;
      end
      COL_GV: begin
        kc = K_GV;
        dc = dv;
      end
      default: begin
        kc = '0;
        dc = '0;
      end
    endcase
  end

  assign cprod = kc * dc;
  assign ybase = $signed({3'b000, luma_q, 16'h0000});

  always_ff @(posedge clk_i) begin
    case (cmd_i.col)
      COL_B:  b_q <= ybase + cprod;
      COL_R:  r_q <= ybase + cprod;
      COL_GU: g_q <= ybase - cprod;
      COL_GV: g_q <= g_q - cprod;
      default: ;
    endcase
  end

  logic [OUT_TDATA_W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {clamp_q16(r_q), clamp_q16(g_q), clamp_q16(b_q)};
    end
  end

  assign out_data_o = out_q;

endmodule

### hdl/y2r_checker.sv
// Port-level checks for the converter top level, with their bind.
`timescale 1ns / 1ps
module y2r_checker
  import y2r_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // a pixel word occupies the converter, so input closes next cycle
  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_PIXEL) |=> !s_axis_tready)
    else $error("input open right after a pixel word");

  // a load word does not occupy the converter, so input stays open
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_LOAD) |=> s_axis_tready)
    else $error("input closed after a load word");

endmodule

bind yuv420_frame_to_rgb_converter_unit y2r_checker u_y2r_checker (.*);

### tb/yuv420_frame_to_rgb_converter_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the YUV 4:2:0 frame store and BT.601 pixel converter.
module yuv420_frame_to_rgb_converter_unit_test;
  import y2r_pkg::*;

  localparam logic [LAYOUT_W-1:0] LAYOUT_UNKNOWN = 3'd4;
  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PHASE_WORDS   = 85;
  localparam int          N_SETTINGS    = 11;
  localparam int          N_FIXED       = 8;

  // Q16 coefficients, full-range BT.601
  localparam longint B_FROM_U = 116130;
  localparam longint G_FROM_U = 22554;
  localparam longint G_FROM_V = 46802;
  localparam longint R_FROM_V = 91881;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } bgr_t;

  class bgr_scoreboard;
    byte unsigned        frame_mem [STORE_BYTES];
    bit                  loaded [STORE_BYTES];
    int unsigned         width_px;
    int unsigned         height_px;
    logic [LAYOUT_W-1:0] layout;
    bgr_t                due [$];
    int                  mismatches;
    int                  checked;

    function new();
      width_px   = 256;
      height_px  = 256;
      layout     = LAYOUT_NV12;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_WIDTH:  width_px  = 32'(value);
        CFG_HEIGHT: height_px = 32'(value);
        CFG_LAYOUT: layout    = value[LAYOUT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned luma_addr(int unsigned col, int unsigned row);
      return row * width_px + col;
    endfunction

    // second picks the odd byte of an interleaved pair, or the second planar plane
    function int unsigned chroma_addr(int unsigned col, int unsigned row, bit second);
      int unsigned pair_row;
      int unsigned half_w;
      int unsigned half_h;
      int unsigned addr;
      pair_row = row / 2;
      half_w   = width_px / 2;
      half_h   = height_px / 2;
      if (layout == LAYOUT_NV21 || layout == LAYOUT_NV12) begin
        // odd widths pad the interleaved row to an even stride
        addr = width_px * height_px + pair_row * (width_px + width_px % 2)
               + (col - col % 2) + second;
      end else begin
        addr = width_px * height_px + pair_row * half_w + col / 2;
        if (second) addr += half_w * half_h;
        if (width_px % 2 == 1) addr += pair_row + (second ? half_h : 0);
      end
      return addr;
    endfunction

    function bit chroma_known();
      return layout <= LAYOUT_YV12;
    endfunction

    function bit u_in_second();
      return layout == LAYOUT_NV21 || layout == LAYOUT_YV12;
    endfunction

    function int unsigned fetch(int unsigned addr);
      if (addr >= STORE_BYTES) return 0;
      return frame_mem[addr];
    endfunction

    function logic [PIX_W-1:0] sat_q16(longint acc);
      longint whole;
      if (acc < 0) return '0;
      whole = acc / 65536;
      return (whole > 255) ? 8'hFF : whole[PIX_W-1:0];
    endfunction

    function bgr_t predict_bgr(int unsigned col, int unsigned row);
      longint luma;
      longint du;
      longint dv;
      int unsigned u_val;
      int unsigned v_val;
      bgr_t px;
      u_val = 0;
      v_val = 0;
      luma  = fetch(luma_addr(col, row));
      if (chroma_known()) begin
        u_val = fetch(chroma_addr(col, row, u_in_second()));
        v_val = fetch(chroma_addr(col, row, !u_in_second()));
      end
      du = longint'(u_val) - 128;
      dv = longint'(v_val) - 128;
      px.blue  = sat_q16(luma * 65536 + B_FROM_U * du);
      px.green = sat_q16(luma * 65536 - G_FROM_U * du - G_FROM_V * dv);
      px.red   = sat_q16(luma * 65536 + R_FROM_V * dv);
      return px;
    endfunction

    function void note_word(logic kind, logic [IN_TDATA_W-1:0] data);
      int unsigned addr;
      addr = 32'(data[IN_ADDR_LSB +: MEM_AW]);
      if (kind == KIND_LOAD) begin
        frame_mem[addr] = data[IN_VALUE_LSB +: PIX_W];
        loaded[addr]    = 1'b1;
      end else begin
        due.push_back(predict_bgr(data[IN_COL_LSB +: COORD_W], data[IN_ROW_LSB +: COORD_W]));
      end
    endfunction

    function void flag(string what, bgr_t want, bgr_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR %s: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                 what, want.blue, want.green, want.red, got.blue, got.green, got.red);
    endfunction

    function void check_result(bgr_t got);
      bgr_t want;
      checked++;
      if (due.size() == 0) begin
        flag("result with nothing due", '0, got);
        return;
      end
      want = due.pop_front();
      if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red)
        flag("pixel mismatch", want, got);
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  bgr_scoreboard sb = new();

  int          burst_left   = 0;
  bit          bus_held     = 1'b0;
  bit          no_gaps      = 1'b0;
  int          words_sent   = 0;
  int          pixels_sent  = 0;
  int          loads_sent   = 0;
  int          settings_run = 1;
  bit          hold_request = 1'b0;
  int          hold_left    = 0;
  int          ready_mode   = 0;
  int          mode_left    = 0;
  int unsigned pattern_step = 0;
  int unsigned cycle_count  = 0;

  yuv420_frame_to_rgb_converter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, sb.due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: switch between stall modes, or hold off entirely on request
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(3);
        mode_left  = $urandom_range(40, 300);
      end
      mode_left--;
      pattern_step++;
      case (ready_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(1) == 1);
        2:       m_axis_tready <= ($urandom_range(5) == 0);
        default: m_axis_tready <= (pattern_step % 9) < 5;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  function automatic logic [IN_TDATA_W-1:0] pack_word(int unsigned addr, int unsigned value,
                                                      int unsigned col, int unsigned row);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[IN_ADDR_LSB +: MEM_AW]  = MEM_AW'(addr);
    w[IN_VALUE_LSB +: PIX_W]  = PIX_W'(value);
    w[IN_COL_LSB +: COORD_W]  = COORD_W'(col);
    w[IN_ROW_LSB +: COORD_W]  = COORD_W'(row);
    return w;
  endfunction

  function automatic int unsigned pick_byte();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 255;
      2:       return 128;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Mostly inside the frame, sometimes anywhere the field reaches
  function automatic int unsigned pick_coord(int unsigned extent);
    int unsigned top;
    top = (extent > 256) ? 255 : extent - 1;
    if ($urandom_range(3) != 0) return $urandom_range(top);
    return $urandom_range(255);
  endfunction

  task automatic send_word(input logic kind, input logic [IN_TDATA_W-1:0] data);
    if (burst_left == 0) begin
      // a fresh burst after an idle bus always starts with an idle gap
      if (!no_gaps || !bus_held) begin
        if (bus_held) begin
          s_axis_tvalid <= 1'b0;
          bus_held = 1'b0;
        end
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= kind;
    bus_held = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(kind, data);
    burst_left--;
    words_sent++;
    if (kind == KIND_PIXEL) pixels_sent++;
    else loads_sent++;
  endtask

  task automatic release_bus();
    if (bus_held) begin
      s_axis_tvalid <= 1'b0;
      bus_held = 1'b0;
    end
    burst_left = 0;
  endtask

  task automatic drain();
    release_bus();
    @(posedge clk_i);
    while (sb.due.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_byte(input int unsigned addr, input int unsigned value);
    send_word(KIND_LOAD, pack_word(addr, value, $urandom_range(255), $urandom_range(255)));
  endtask

  // Load any byte the pixel reads that was never written, then ask for the pixel
  task automatic convert(input int unsigned col, input int unsigned row);
    int unsigned reads [3];
    int n_reads;
    reads[0] = sb.luma_addr(col, row);
    n_reads  = 1;
    if (sb.chroma_known()) begin
      reads[1] = sb.chroma_addr(col, row, 1'b0);
      reads[2] = sb.chroma_addr(col, row, 1'b1);
      n_reads  = 3;
    end
    for (int i = 0; i < n_reads; i++)
      if (reads[i] < STORE_BYTES && !sb.loaded[reads[i]])
        load_byte(reads[i], $urandom_range(255));
    send_word(KIND_PIXEL, pack_word($urandom_range(STORE_BYTES - 1), $urandom_range(255),
                                    col, row));
  endtask

  task automatic paint_pixel(input int unsigned col, input int unsigned row,
                             input int unsigned y_val, input int unsigned u_val,
                             input int unsigned v_val);
    int unsigned addr;
    addr = sb.luma_addr(col, row);
    if (addr < STORE_BYTES) load_byte(addr, y_val);
    if (sb.chroma_known()) begin
      addr = sb.chroma_addr(col, row, sb.u_in_second());
      if (addr < STORE_BYTES) load_byte(addr, u_val);
      addr = sb.chroma_addr(col, row, !sb.u_in_second());
      if (addr < STORE_BYTES) load_byte(addr, v_val);
    end
    convert(col, row);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, value[CFG_DATA_W-1:0]);
  endtask

  // Wait for the block to go idle before touching its registers
  task automatic configure(input int unsigned w, input int unsigned h,
                           input logic [LAYOUT_W-1:0] lay);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_LAYOUT, lay);
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  task automatic random_traffic(input int words);
    int stop_at;
    int r;
    int unsigned extent;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      if ($urandom_range(39) == 0) no_gaps = !no_gaps;
      r = $urandom_range(99);
      if (r < 40) begin
        paint_pixel(pick_coord(sb.width_px), pick_coord(sb.height_px),
                    pick_byte(), pick_byte(), pick_byte());
      end else if (r < 70) begin
        convert(pick_coord(sb.width_px), pick_coord(sb.height_px));
      end else if (r < 88) begin
        // rewrite bytes around the active planes
        extent = sb.width_px * sb.height_px * 3 / 2 + sb.width_px + sb.height_px;
        if (extent > STORE_BYTES) extent = STORE_BYTES;
        load_byte($urandom_range(extent - 1), $urandom_range(255));
      end else if (r < 98) begin
        load_byte($urandom_range(STORE_BYTES - 1), $urandom_range(255));
      end else begin
        drain();
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic flood_during_hold();
    no_gaps      = 1'b1;
    hold_request = 1'b1;
    repeat (24) convert(pick_coord(sb.width_px), pick_coord(sb.height_px));
    no_gaps = 1'b0;
  endtask

  int unsigned fixed_w [N_FIXED] = '{1, 17, 255, 256, 40, 511, 2, 256};
  int unsigned fixed_h [N_FIXED] = '{1, 9, 128, 256, 30, 300, 256, 1};
  logic [LAYOUT_W-1:0] fixed_lay [N_FIXED] = '{LAYOUT_NV21, LAYOUT_YU12, LAYOUT_YV12,
                                               LAYOUT_NV21, LAYOUT_UNKNOWN, LAYOUT_NV12,
                                               LAYOUT_YV12, LAYOUT_YU12};

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 256 x 256 NV12; corners, mid-gray and saturating colors
    load_byte(STORE_BYTES - 1, 8'hA5);
    paint_pixel(0, 0, 0, 0, 0);
    paint_pixel(255, 255, 255, 255, 255);
    paint_pixel(1, 1, 128, 128, 128);
    paint_pixel(254, 3, 255, 0, 255);
    paint_pixel(7, 200, 0, 255, 0);
    flood_during_hold();
    random_traffic(PHASE_WORDS);

    // small, odd, wide, unknown-layout and oversized frames, then random ones
    for (int i = 0; i < N_SETTINGS; i++) begin
      if (i < N_FIXED)
        configure(fixed_w[i], fixed_h[i], fixed_lay[i]);
      else
        configure($urandom_range(1, 256), $urandom_range(1, 256),
                  LAYOUT_W'($urandom_range(0, 4)));
      random_traffic(PHASE_WORDS);
    end

    drain();
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    $display("sent %0d words (%0d loads, %0d pixels) across %0d frame settings",
             words_sent, loads_sent, pixels_sent, settings_run);
    $display("checked %0d results, %0d mismatched", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### yuv420_frame_to_rgb_converter_unit.f
hdl/y2r_pkg.sv
hdl/y2r_ctrl.sv
hdl/y2r_datapath.sv
hdl/yuv420_frame_to_rgb_converter_unit.sv
hdl/y2r_checker.sv
tb/yuv420_frame_to_rgb_converter_unit_test.sv
